>>> hw/rtl/backslash_escape_decoder_macros.svh
// assertion helpers, clocked on clk
`ifndef BACKSLASH_ESCAPE_DECODER_MACROS_SVH
`define BACKSLASH_ESCAPE_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked only outside reset
`define BSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bsd assertion failed");
// checked during reset too
`define BSD_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("bsd reset assertion failed");
`else
`define BSD_ASSERT(lbl, prop)
`define BSD_ASSERT_RST(lbl, prop)
`endif

`endif

>>> hw/rtl/bsd_pkg.sv
package bsd_pkg;

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [2:0] HEX_DIGITS = 3'd2;
  localparam logic [2:0] OCT_DIGITS = 3'd4;
  localparam int unsigned MAX_RES  = 3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
    logic       new_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       halt;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       halt;
  } res_item_t;

  // results of one request, entry 0 goes out first
  typedef struct packed {
    res_item_t [0:MAX_RES-1] item;
    logic [1:0]              cnt;
  } res_list_t;

  typedef enum logic [3:0] {
    MODE_PLAIN = 4'b0001,
    MODE_ESC   = 4'b0010,
    MODE_HEX   = 4'b0100,
    MODE_OCT   = 4'b1000
  } esc_mode_t;

  // append one result, extra results past the list size are dropped
  function automatic res_list_t push(res_list_t l, logic [7:0] b, logic h);
    res_list_t r;
    r = l;
    if (l.cnt < 2'(MAX_RES)) begin
      r.item[l.cnt] = '{out_byte: b, halt: h};
      r.cnt = l.cnt + 2'd1;
    end
    return r;
  endfunction

  // {valid, digit value}
  function automatic logic [4:0] hex_of(logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  // {valid, control byte}
  function automatic logic [8:0] control_of(logic [7:0] b);
    logic [8:0] r;
    unique case (b)
      8'h61:     r = {1'b1, 8'd7};
      8'h62:     r = {1'b1, 8'd8};
      8'h66:     r = {1'b1, 8'd12};
      8'h6e:     r = {1'b1, 8'd10};
      8'h72:     r = {1'b1, 8'd13};
      8'h74:     r = {1'b1, 8'd9};
      8'h76:     r = {1'b1, 8'd11};
      CH_BSLASH: r = {1'b1, CH_BSLASH};
      default:   r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/backslash_escape_decoder.sv
// channel | ports                                | payload
// in      | in_valid, in_ready, in_data          | bsd_pkg::in_item_t
// out     | out_valid, out_ready, out_data       | bsd_pkg::out_item_t
// cfg     | cfg_wr_en, cfg_wr_data               | unescape_enable
// a request is decoded in the cycle it is taken; its results (0 to 3) sit in the result
// buffer and leave one per cycle while out_ready is high, the first in the next cycle
// k > 1 results hold in_ready low until one is left; else 1 request per cycle if out_ready
// in_ready is high while the buffer is empty or its last result is being taken
// reset is synchronous on rst_n low: plain text, not halted, escapes off, buffer empty
`include "backslash_escape_decoder_macros.svh"

module backslash_escape_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bsd_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bsd_pkg::out_item_t  out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);

  bsd_pkg::esc_mode_t  mode_r, mode_nxt;
  logic [2:0]          dcnt_r, dcnt_nxt;
  logic [8:0]          acc_r, acc_nxt;
  logic                halted_r, halted_nxt;
  logic                en_r;
  bsd_pkg::res_item_t [0:bsd_pkg::MAX_RES-1] buf_r;
  logic [1:0]          cnt_r;

  bsd_pkg::res_list_t  lst;
  logic                plain_b;
  logic [4:0]          hx;
  logic [8:0]          ctl;
  logic [7:0]          b;
  logic                in_acc;
  logic                out_take;

  assign b        = in_data.in_byte;
  assign in_ready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);
  assign in_acc   = in_valid && in_ready;
  assign out_valid = cnt_r != 2'd0;
  assign out_take  = out_valid && out_ready;

  assign out_data.out_byte    = buf_r[0].out_byte;
  assign out_data.halt        = buf_r[0].halt;
  assign out_data.last_of_run = cnt_r == 2'd1;

  always_comb begin
    mode_nxt   = mode_r;
    dcnt_nxt   = dcnt_r;
    acc_nxt    = acc_r;
    halted_nxt = halted_r;
    lst        = '0;
    plain_b    = 1'b0;
    hx         = bsd_pkg::hex_of(b);
    ctl        = bsd_pkg::control_of(b);
    if (in_data.new_text) begin
      halted_nxt = 1'b0;
      mode_nxt   = bsd_pkg::MODE_PLAIN;
      dcnt_nxt   = '0;
      acc_nxt    = '0;
    end
    if (!halted_nxt) begin
      if (!en_r) begin
        mode_nxt = bsd_pkg::MODE_PLAIN;
        dcnt_nxt = '0;
        acc_nxt  = '0;
        lst      = bsd_pkg::push(lst, b, 1'b0);
      end else begin
        unique case (mode_nxt)
          bsd_pkg::MODE_PLAIN: plain_b = 1'b1;
          bsd_pkg::MODE_ESC: begin
            mode_nxt = bsd_pkg::MODE_PLAIN;
            dcnt_nxt = '0;
            acc_nxt  = '0;
            if (b == bsd_pkg::CH_C) begin
              lst        = bsd_pkg::push(lst, 8'd0, 1'b1);
              halted_nxt = 1'b1;
            end else if (b == bsd_pkg::CH_X) begin
              mode_nxt = bsd_pkg::MODE_HEX;
            end else if (b == bsd_pkg::CH_ZERO) begin
              mode_nxt = bsd_pkg::MODE_OCT;
              dcnt_nxt = 3'd1;
            end else if (ctl[8]) begin
              lst = bsd_pkg::push(lst, ctl[7:0], 1'b0);
            end else begin
              lst = bsd_pkg::push(lst, bsd_pkg::CH_BSLASH, 1'b0);
              lst = bsd_pkg::push(lst, b, 1'b0);
            end
          end
          bsd_pkg::MODE_HEX: begin
            if (hx[4]) begin
              acc_nxt  = {acc_nxt[4:0], hx[3:0]};
              dcnt_nxt = dcnt_nxt + 3'd1;
              if (dcnt_nxt >= bsd_pkg::HEX_DIGITS) begin
                lst      = bsd_pkg::push(lst, acc_nxt[7:0], 1'b0);
                mode_nxt = bsd_pkg::MODE_PLAIN;
                dcnt_nxt = '0;
                acc_nxt  = '0;
              end
            end else begin
              // no digits yet: the escape stays literal
              if (dcnt_nxt == 3'd0) begin
                lst = bsd_pkg::push(lst, bsd_pkg::CH_BSLASH, 1'b0);
                lst = bsd_pkg::push(lst, bsd_pkg::CH_X, 1'b0);
              end else begin
                lst = bsd_pkg::push(lst, acc_nxt[7:0], 1'b0);
              end
              mode_nxt = bsd_pkg::MODE_PLAIN;
              dcnt_nxt = '0;
              acc_nxt  = '0;
              plain_b  = 1'b1;
            end
          end
          bsd_pkg::MODE_OCT: begin
            if (b >= bsd_pkg::CH_ZERO && b <= bsd_pkg::CH_SEVEN &&
                dcnt_nxt < bsd_pkg::OCT_DIGITS) begin
              acc_nxt  = {acc_nxt[5:0], b[2:0]};
              dcnt_nxt = dcnt_nxt + 3'd1;
              if (dcnt_nxt >= bsd_pkg::OCT_DIGITS) begin
                lst      = bsd_pkg::push(lst, acc_nxt[7:0], 1'b0);
                mode_nxt = bsd_pkg::MODE_PLAIN;
                dcnt_nxt = '0;
                acc_nxt  = '0;
              end
            end else begin
              lst      = bsd_pkg::push(lst, acc_nxt[7:0], 1'b0);
              mode_nxt = bsd_pkg::MODE_PLAIN;
              dcnt_nxt = '0;
              acc_nxt  = '0;
              plain_b  = 1'b1;
            end
          end
          default: ;
        endcase
        // byte handled as plain text, possibly opening a new escape
        if (plain_b) begin
          if (b == bsd_pkg::CH_BSLASH) begin
            mode_nxt = bsd_pkg::MODE_ESC;
            dcnt_nxt = '0;
            acc_nxt  = '0;
          end else begin
            lst = bsd_pkg::push(lst, b, 1'b0);
          end
        end
        if (!halted_nxt && in_data.end_of_text) begin
          unique case (mode_nxt)
            bsd_pkg::MODE_ESC: lst = bsd_pkg::push(lst, bsd_pkg::CH_BSLASH, 1'b0);
            bsd_pkg::MODE_HEX: begin
              if (dcnt_nxt == 3'd0) begin
                lst = bsd_pkg::push(lst, bsd_pkg::CH_BSLASH, 1'b0);
                lst = bsd_pkg::push(lst, bsd_pkg::CH_X, 1'b0);
              end else begin
                lst = bsd_pkg::push(lst, acc_nxt[7:0], 1'b0);
              end
            end
            bsd_pkg::MODE_OCT: lst = bsd_pkg::push(lst, acc_nxt[7:0], 1'b0);
            default: ;
          endcase
        end
        if (halted_nxt || in_data.end_of_text) begin
          mode_nxt = bsd_pkg::MODE_PLAIN;
          dcnt_nxt = '0;
          acc_nxt  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= bsd_pkg::MODE_PLAIN;
      dcnt_r   <= '0;
      acc_r    <= '0;
      halted_r <= 1'b0;
      en_r     <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        en_r <= cfg_wr_data;
      end
      if (in_acc) begin
        mode_r   <= mode_nxt;
        dcnt_r   <= dcnt_nxt;
        acc_r    <= acc_nxt;
        halted_r <= halted_nxt;
        cnt_r    <= lst.cnt;
      end else if (out_take) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      buf_r <= lst.item;
    end else if (out_take) begin
      buf_r[0] <= buf_r[1];
      buf_r[1] <= buf_r[2];
    end
  end

  `BSD_ASSERT_RST(a_reset_empties, !rst_n |=> cnt_r == 2'd0)
  `BSD_ASSERT(a_halt_is_last, out_valid && out_data.halt |-> out_data.last_of_run)
  `BSD_ASSERT(a_halt_zero_byte, out_valid && out_data.halt |-> out_data.out_byte == 8'd0)
  `BSD_ASSERT(a_halted_silent,
    in_acc && halted_r && !in_data.new_text |=> cnt_r == 2'd0)
  `BSD_ASSERT(a_disabled_plain, in_acc && !en_r |=> mode_r == bsd_pkg::MODE_PLAIN)

endmodule
